// ----- rtl/rdu_pkg.sv -----
package rdu_pkg;

  localparam int unsigned WIDTH_DEFAULT = 8;

  function automatic int unsigned byte_pad(input int unsigned bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

// ----- rtl/rdu_stage.sv -----
module rdu_stage #(
  parameter int unsigned WIDTH = rdu_pkg::WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH:0]   in_acc,
  input  logic [WIDTH-1:0] in_quo,
  input  logic [WIDTH-1:0] in_den,
  input  logic             in_dbz,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH:0]   out_acc,
  output logic [WIDTH-1:0] out_quo,
  output logic [WIDTH-1:0] out_den,
  output logic             out_dbz
);
  import rdu_pkg::*;

  logic [WIDTH:0]   acc_shift;
  logic [WIDTH:0]   den_ext;
  logic [WIDTH:0]   diff;
  logic             fits;
  logic [WIDTH:0]   acc_next;
  logic [WIDTH-1:0] quo_next;
  logic             load;

  assign acc_shift = {in_acc[WIDTH-1:0], in_quo[WIDTH-1]};
  assign den_ext   = {1'b0, in_den};
  assign diff      = acc_shift - den_ext;
  assign fits      = acc_shift >= den_ext;
  assign acc_next  = fits ? diff : acc_shift;
  assign quo_next  = {in_quo[WIDTH-2:0], fits};

  // advance when empty or when the next stage takes our item
  assign load     = !out_valid || out_ready;
  assign in_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_acc <= acc_next;
      out_quo <= quo_next;
      out_den <= in_den;
      out_dbz <= in_dbz;
    end
  end

endmodule

// ----- rtl/restoring_divider_unit.sv -----
// Unsigned restoring divider, pipelined one stage per quotient bit. Each
// transfer on the s_ side carries a dividend and divisor; the matching
// quotient and remainder leave on the m_ side, in order, after passing
// through the chain of WIDTH registered subtract-and-restore stages, each
// holding one (WIDTH+1)-bit subtract and compare. While m_ is not stalled,
// a new transfer is taken every cycle, so throughput is one division per clock.
// Back pressure on m_ fills empty stages first and only then stalls s_.
// A zero divisor returns an all-ones quotient, the dividend as remainder,
// and m_tuser set.
module restoring_divider_unit #(
  parameter int unsigned WIDTH = rdu_pkg::WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // dividend [WIDTH-1:0], divisor [2*WIDTH-1:WIDTH], zero padding
  input  logic [rdu_pkg::byte_pad(2*WIDTH)-1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // quotient [WIDTH-1:0], remainder [2*WIDTH-1:WIDTH], zero padding
  output logic [rdu_pkg::byte_pad(2*WIDTH)-1:0] m_tdata,
  // divide_by_zero [0]
  output logic                                  m_tuser
);
  import rdu_pkg::*;

  localparam int unsigned DATA_W = byte_pad(2*WIDTH);

  logic             valid_c [0:WIDTH];
  logic             ready_c [0:WIDTH];
  logic [WIDTH:0]   acc_c   [0:WIDTH];
  logic [WIDTH-1:0] quo_c   [0:WIDTH];
  logic [WIDTH-1:0] den_c   [0:WIDTH];
  logic             dbz_c   [0:WIDTH];

  assign valid_c[0] = s_tvalid;
  assign s_tready   = ready_c[0];
  assign acc_c[0]   = '0;
  assign quo_c[0]   = s_tdata[WIDTH-1:0];
  assign den_c[0]   = s_tdata[2*WIDTH-1:WIDTH];
  assign dbz_c[0]   = (s_tdata[2*WIDTH-1:WIDTH] == '0);

  for (genvar i = 0; i < WIDTH; i++) begin : g_stage
    rdu_stage #(
      .WIDTH(WIDTH)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (valid_c[i]),
      .in_ready (ready_c[i]),
      .in_acc   (acc_c[i]),
      .in_quo   (quo_c[i]),
      .in_den   (den_c[i]),
      .in_dbz   (dbz_c[i]),
      .out_valid(valid_c[i+1]),
      .out_ready(ready_c[i+1]),
      .out_acc  (acc_c[i+1]),
      .out_quo  (quo_c[i+1]),
      .out_den  (den_c[i+1]),
      .out_dbz  (dbz_c[i+1])
    );
  end

  assign ready_c[WIDTH] = m_tready;
  assign m_tvalid       = valid_c[WIDTH];
  assign m_tuser        = dbz_c[WIDTH];

  if (DATA_W > 2*WIDTH) begin : g_pad
    assign m_tdata = {{(DATA_W-2*WIDTH){1'b0}}, acc_c[WIDTH][WIDTH-1:0], quo_c[WIDTH]};
  end else begin : g_nopad
    assign m_tdata = {acc_c[WIDTH][WIDTH-1:0], quo_c[WIDTH]};
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while pipeline tail is empty");

  a_dbz_quo: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[WIDTH-1:0] == {WIDTH{1'b1}}))
    else $error("zero divisor without all-ones quotient");

  a_stall_take: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result lost while stalled");

endmodule

// ----- test/restoring_divider_checker.sv -----
module restoring_divider_checker #(
  parameter int unsigned WIDTH = rdu_pkg::WIDTH_DEFAULT,
  parameter int unsigned DW    = rdu_pkg::byte_pad(2*WIDTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [DW-1:0]     s_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [DW-1:0]     m_tdata,
  input  logic              m_tuser,
  output int unsigned       fail_count,
  output int unsigned       pending,
  output int unsigned       results_checked,
  output int unsigned       zero_divisions
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
    logic             divide_by_zero;
  } division_t;

  division_t pending_divisions[$];

  function automatic division_t divide_restoring(input logic [WIDTH-1:0] num,
                                                 input logic [WIDTH-1:0] den);
    division_t      res;
    logic [WIDTH:0] acc;
    logic [WIDTH-1:0] quo;
    if (den == '0) begin
      res.quotient       = '1;
      res.remainder      = num;
      res.divide_by_zero = 1'b1;
      return res;
    end
    acc = '0;
    quo = num;
    for (int i = 0; i < WIDTH; i++) begin
      acc = {acc[WIDTH-1:0], quo[WIDTH-1]};
      quo = quo << 1;
      if (acc >= {1'b0, den}) begin
        acc    = acc - {1'b0, den};
        quo[0] = 1'b1;
      end
    end
    res.quotient       = quo;
    res.remainder      = acc[WIDTH-1:0];
    res.divide_by_zero = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    division_t want;
    division_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.quotient       = m_tdata[WIDTH-1:0];
        got.remainder      = m_tdata[2*WIDTH-1:WIDTH];
        got.divide_by_zero = m_tuser;
        if (pending_divisions.size() == 0) begin
          $error("result transfer with no division outstanding: q=%0d r=%0d dbz=%0b",
                 got.quotient, got.remainder, got.divide_by_zero);
          fail_count++;
        end else begin
          want = pending_divisions.pop_front();
          results_checked++;
          if (got.quotient !== want.quotient) begin
            $error("quotient: expected %0d, actual %0d", want.quotient, got.quotient);
            fail_count++;
          end
          if (got.remainder !== want.remainder) begin
            $error("remainder: expected %0d, actual %0d", want.remainder, got.remainder);
            fail_count++;
          end
          if (got.divide_by_zero !== want.divide_by_zero) begin
            $error("divide_by_zero: expected %0b, actual %0b",
                   want.divide_by_zero, got.divide_by_zero);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = divide_restoring(s_tdata[WIDTH-1:0], s_tdata[2*WIDTH-1:WIDTH]);
        if (want.divide_by_zero) zero_divisions++;
        pending_divisions.push_back(want);
      end
      pending = pending_divisions.size();
    end
  end

endmodule

// ----- test/restoring_divider_unit_tb.sv -----
module restoring_divider_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIDTH     = rdu_pkg::WIDTH_DEFAULT;
  localparam int unsigned DW        = rdu_pkg::byte_pad(2*WIDTH);
  localparam int unsigned N_RANDOM  = 1450;
  localparam int unsigned N_DIRECT  = 22;

  logic          clk      = 1'b0;
  logic          rst      = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [DW-1:0] s_tdata  = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [DW-1:0] m_tdata;
  logic          m_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_checked;
  int unsigned zero_divisions;
  int unsigned burst_left = 0;
  int unsigned long_holds = 0;

  always #5 clk = ~clk;

  restoring_divider_unit #(.WIDTH(WIDTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  restoring_divider_checker #(.WIDTH(WIDTH), .DW(DW)) u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .zero_divisions  (zero_divisions)
  );

  initial begin
    #2ms;
    $display("FAIL restoring_divider_unit");
    $finish;
  end

  // send one division, inserting a random gap between bursts
  task automatic send_division(input logic [WIDTH-1:0] num, input logic [WIDTH-1:0] den);
    logic [DW-1:0] word;
    int unsigned   gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    word                  = '0;
    word[2*WIDTH-1:0]     = {den, num};
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  // hold the input idle until every division has come back
  task automatic drain_results();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // receiver: stretches of always-ready, random ready, and long hold-offs
  initial begin
    int unsigned stretch;
    int unsigned len;
    int unsigned mode;
    stretch = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      mode = (stretch % 6 == 3) ? 2 : $urandom_range(0, 1);
      if (mode == 2) begin
        len = $urandom_range(40, 80);
        long_holds++;
      end else begin
        len = $urandom_range(20, 200);
      end
      for (int c = 0; c < len; c++) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= 1'b0;
        endcase
        @(posedge clk);
      end
      stretch++;
    end
  end

  initial begin
    logic [WIDTH-1:0] dir_num [N_DIRECT];
    logic [WIDTH-1:0] dir_den [N_DIRECT];
    logic [WIDTH-1:0] num;
    logic [WIDTH-1:0] den;
    int unsigned      pick;
    dir_num = '{8'd0,   8'd255, 8'd0,   8'd255, 8'd255, 8'd1,   8'd128, 8'd127,
                8'd200, 8'd255, 8'd128, 8'd170, 8'd85,  8'd7,   8'd254, 8'd255,
                8'd100, 8'd99,  8'd1,   8'd129, 8'd255, 8'd64};
    dir_den = '{8'd0,   8'd0,   8'd255, 8'd255, 8'd1,   8'd255, 8'd128, 8'd128,
                8'd7,   8'd128, 8'd255, 8'd85,  8'd170, 8'd0,   8'd127, 8'd2,
                8'd100, 8'd100, 8'd1,   8'd129, 8'd254, 8'd3};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECT; i++) send_division(dir_num[i], dir_den[i]);
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      num  = WIDTH'($urandom_range(0, 255));
      den  = WIDTH'($urandom_range(0, 255));
      if (pick < 50) begin
      end else if (pick < 62) begin
        den = WIDTH'($urandom_range(1, 15));
      end else if (pick < 70) begin
        den = '0;
      end else if (pick < 80) begin
        den = WIDTH'($urandom_range(128, 255));
      end else if (pick < 90) begin
        den = WIDTH'($urandom_range(1, 255));
        num = WIDTH'($urandom_range(0, den - 1));
      end else begin
        den = WIDTH'($urandom_range(1, 255));
        num = WIDTH'(den * $urandom_range(0, 255 / den) + $urandom_range(0, 1));
      end
      send_division(num, den);
      if (i == N_RANDOM / 2) drain_results();
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2*WIDTH + 4) @(posedge clk);

    $display("Checked %0d divisions (%0d by zero), directed extremes plus random operands,",
             results_checked, zero_divisions);
    $display("under bursty input, %0d long output hold-offs and two full drains.",
             long_holds);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS restoring_divider_unit");
    end else begin
      $display("FAIL restoring_divider_unit");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rdu_pkg.sv
rtl/rdu_stage.sv
rtl/restoring_divider_unit.sv
test/restoring_divider_checker.sv
test/restoring_divider_unit_tb.sv
